/* rtl/core/packet_aggregation_framer_defines.svh */
// Assertion macros shared by the framer checker.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef PACKET_AGGREGATION_FRAMER_DEFINES_SVH
`define PACKET_AGGREGATION_FRAMER_DEFINES_SVH

// Checked outside reset.
`define PAF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every edge, reset included.
`define PAF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/core/paf_pkg.sv */
// ----------------------------------------------------------------------------
// Packet aggregation framer package
// Shared codes, datapath operations and controller/datapath interface types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package paf_pkg;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_BUSY   = 2'd1;
  localparam logic [1:0] ST_BIG    = 2'd2;
  localparam logic [1:0] ST_NOREAD = 2'd3;

  localparam logic [1:0] OPC_PKT  = 2'd0;
  localparam logic [1:0] OPC_TICK = 2'd1;
  localparam logic [1:0] OPC_READ = 2'd2;

  localparam logic [1:0] REG_MAX_FRAME_BYTES = 2'd0;
  localparam logic [1:0] REG_MAX_PACKETS     = 2'd1;
  localparam logic [1:0] REG_COALESCE_TICKS  = 2'd2;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LATCH,
    OP_DROP,
    OP_REJECT_BIG,
    OP_REJECT_BUSY,
    OP_TICK,
    OP_NOREAD,
    OP_READ,
    OP_PKT_START,
    OP_ZERO,
    OP_DATA,
    OP_PAD,
    OP_ADTH,
    OP_TAB,
    OP_HDR,
    OP_FIN,
    OP_EMIT
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic [3:0] j;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] opcode;
    logic       dropping;
    logic       in_packet;
    logic       too_large;
    logic       need_close;
    logic       frame_rdy;
    logic       pad_done;
    logic       tab_last;
    logic       close_due;
    logic       out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

/* rtl/core/paf_datapath.sv */
// ----------------------------------------------------------------------------
// Packet aggregation framer datapath
// Frame store, bounds table, frame state registers and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module paf_datapath import paf_pkg::*; #(
  parameter int FRAME_BYTES = 4096,
  parameter int MAX_PACKETS = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire dp_cmd_t     cmd,
  output dp_stat_t         stat,
  input  wire logic        cfg_wen,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_wdata,
  input  wire logic [1:0]  in_opcode,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic [11:0] in_packet_length,
  input  wire logic        in_last_byte,
  output logic             out_valid,
  input  wire logic        out_taken,
  output logic [1:0]       out_status,
  output logic [7:0]       out_byte,
  output logic             out_frame_end,
  output logic             out_frame_ready
);

  localparam int AW = $clog2(FRAME_BYTES);
  localparam int OW = $clog2(FRAME_BYTES + 1);
  localparam int CW = $clog2(MAX_PACKETS + 1);
  localparam int IW = (MAX_PACKETS > 1) ? $clog2(MAX_PACKETS) : 1;
  localparam int FW = 20;

  function automatic logic [FW-1:0] align4(input logic [FW-1:0] x);
    logic [FW-1:0] s;
    s = x + FW'(3);
    return {s[FW-1:2], 2'b00};
  endfunction

  logic [12:0] max_frame_bytes;
  logic [6:0]  max_packets;
  logic [15:0] coalesce_ticks;

  logic [1:0]  op_r;
  logic [7:0]  data_r;
  logic [11:0] plen_r;
  logic        last_r;

  logic [OW-1:0] fill;
  logic [CW-1:0] count;
  logic [15:0]   seq;
  logic [15:0]   cd;
  logic [AW-1:0] rp;
  logic          bank;
  logic          ready;
  logic          in_packet;
  logic          dropping;
  logic [1:0]    drop_code;
  logic [11:0]   decl;
  logic [11:0]   recv;
  logic [15:0]   start_off;
  logic [15:0]   adth;
  logic [15:0]   total_rd;
  logic [IW-1:0] idx;

  logic [1:0] res_status;
  logic [7:0] res_byte;
  logic       res_fend;

  logic [7:0]  fs_mem [2**(AW+1)];
  logic [7:0]  fs_rdata;
  logic [31:0] bnd_mem [MAX_PACKETS];
  logic [31:0] bnd_rdata;
  logic [IW-1:0] bnd_raddr;

  logic [FW-1:0] lim, mfb, cnt_x, cnt8, len_x, fill_x, need, big_need, limp_x;
  logic [8:0]    mp9, limp9;
  logic [11:0]   len;
  logic [15:0]   alen, total;
  logic          wr_en;
  logic [AW-1:0] wr_off;
  logic [7:0]    wr_data;
  logic          data_en;
  logic [11:0]   recv_new;
  logic [FW-1:0] rp_next_x;

  always_comb begin
    mfb = FW'(max_frame_bytes);
    if (mfb < FW'(64)) begin
      lim = FW'(64);
    end else if (mfb > FW'(FRAME_BYTES)) begin
      lim = FW'(FRAME_BYTES);
    end else begin
      lim = mfb;
    end
    mp9 = {2'b00, max_packets};
    if (mp9 == 9'd0) begin
      limp9 = 9'd1;
    end else if (mp9 > 9'(MAX_PACKETS)) begin
      limp9 = 9'(MAX_PACKETS);
    end else begin
      limp9 = mp9;
    end
    limp_x   = FW'(limp9);
    len      = (plen_r == 12'd0) ? 12'd1 : plen_r;
    len_x    = FW'(len);
    fill_x   = FW'(fill);
    cnt_x    = FW'(count);
    cnt8     = FW'({count, 3'b000});
    need     = align4(fill_x + FW'(16) + len_x) + FW'(16) + cnt8 + FW'(8);
    big_need = align4(FW'(32) + len_x) + FW'(24);
    alen     = 16'(FW'(16) + cnt8);
    total    = 16'(FW'(adth) + FW'(16) + cnt8);
    data_en  = recv < decl;
    recv_new = data_en ? recv + 12'd1 : recv;
    rp_next_x = FW'(rp) + FW'(1);
  end

  always_comb begin
    stat.opcode     = op_r;
    stat.dropping   = dropping;
    stat.in_packet  = in_packet;
    stat.too_large  = big_need > lim;
    stat.need_close = (cnt_x >= limp_x) || (need > lim);
    stat.frame_rdy  = ready;
    stat.pad_done   = (fill[1:0] == 2'b00);
    stat.tab_last   = (FW'(idx) == cnt_x - FW'(1));
    stat.close_due  = !in_packet && !ready && (count != '0) &&
                      ((cnt_x >= limp_x) || (cd == 16'd0));
    stat.out_free   = !out_valid || out_taken;
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_off  = fill[AW-1:0];
    wr_data = 8'd0;
    case (cmd.op)
      OP_ZERO, OP_PAD: begin
        wr_en = 1'b1;
      end
      OP_DATA: begin
        wr_en   = data_en;
        wr_data = data_r;
      end
      OP_ADTH: begin
        wr_en = 1'b1;
        case (cmd.j)
          4'd0: wr_data = 8'h41;
          4'd1: wr_data = 8'h44;
          4'd2: wr_data = 8'h54;
          4'd3: wr_data = 8'h48;
          4'd4: wr_data = alen[7:0];
          4'd5: wr_data = alen[15:8];
          default: wr_data = 8'd0;
        endcase
      end
      OP_TAB: begin
        wr_en = 1'b1;
        case (cmd.j[2:0])
          3'd0: wr_data = bnd_rdata[7:0];
          3'd1: wr_data = bnd_rdata[15:8];
          3'd4: wr_data = bnd_rdata[23:16];
          3'd5: wr_data = bnd_rdata[31:24];
          default: wr_data = 8'd0;
        endcase
      end
      OP_HDR: begin
        wr_en  = 1'b1;
        wr_off = AW'(cmd.j);
        case (cmd.j)
          4'd0:  wr_data = 8'h41;
          4'd1:  wr_data = 8'h44;
          4'd2:  wr_data = 8'h42;
          4'd3:  wr_data = 8'h48;
          4'd6:  wr_data = seq[7:0];
          4'd7:  wr_data = seq[15:8];
          4'd8:  wr_data = total[7:0];
          4'd9:  wr_data = total[15:8];
          4'd12: wr_data = adth[7:0];
          4'd13: wr_data = adth[15:8];
          default: wr_data = 8'd0;
        endcase
      end
      default: wr_en = 1'b0;
    endcase
    if ((cmd.op == OP_TAB) && (cmd.j == 4'd7)) begin
      bnd_raddr = idx + IW'(1);
    end else begin
      bnd_raddr = idx;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      fs_mem[{bank, wr_off}] <= wr_data;
    end
    fs_rdata <= fs_mem[{~bank, rp}];
    if ((cmd.op == OP_DATA) && last_r) begin
      bnd_mem[IW'(count - CW'(1))] <= {16'(recv_new + 12'd16), start_off};
    end
    bnd_rdata <= bnd_mem[bnd_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_frame_bytes <= 13'd4096;
      max_packets     <= 7'd4;
      coalesce_ticks  <= 16'd100;
    end else if (cfg_wen) begin
      case (cfg_index)
        REG_MAX_FRAME_BYTES: max_frame_bytes <= cfg_wdata[12:0];
        REG_MAX_PACKETS:     max_packets     <= cfg_wdata[6:0];
        REG_COALESCE_TICKS:  coalesce_ticks  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill      <= OW'(16);
      count     <= '0;
      seq       <= 16'd0;
      cd        <= 16'd0;
      rp        <= '0;
      bank      <= 1'b0;
      ready     <= 1'b0;
      in_packet <= 1'b0;
      dropping  <= 1'b0;
      drop_code <= ST_OK;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.op == OP_EMIT) begin
        out_valid <= 1'b1;
      end else if (out_taken) begin
        out_valid <= 1'b0;
      end
      case (cmd.op)
        OP_LATCH: begin
          op_r       <= in_opcode;
          data_r     <= in_data_byte;
          plen_r     <= in_packet_length;
          last_r     <= in_last_byte;
          res_status <= ST_OK;
          res_byte   <= 8'd0;
          res_fend   <= 1'b0;
        end
        OP_DROP: begin
          res_status <= drop_code;
          if (last_r) begin
            dropping <= 1'b0;
          end
        end
        OP_REJECT_BIG: begin
          res_status <= ST_BIG;
          drop_code  <= ST_BIG;
          dropping   <= !last_r;
        end
        OP_REJECT_BUSY: begin
          res_status <= ST_BUSY;
          drop_code  <= ST_BUSY;
          dropping   <= !last_r;
        end
        OP_TICK: begin
          if ((count != '0) && (cd != 16'd0)) begin
            cd <= cd - 16'd1;
          end
        end
        OP_NOREAD: res_status <= ST_NOREAD;
        OP_READ: begin
          res_byte <= fs_rdata;
          if (rp_next_x >= FW'(total_rd)) begin
            res_fend <= 1'b1;
            rp       <= '0;
            ready    <= 1'b0;
          end else begin
            rp <= rp + AW'(1);
          end
        end
        OP_PKT_START: begin
          if (count == '0) begin
            cd <= (coalesce_ticks == 16'd0) ? 16'd1 : coalesce_ticks;
          end
          start_off <= 16'(fill);
          count     <= count + CW'(1);
          decl      <= len;
          recv      <= 12'd0;
          in_packet <= 1'b1;
        end
        OP_ZERO, OP_PAD, OP_TAB: fill <= fill + OW'(1);
        OP_ADTH: begin
          fill <= fill + OW'(1);
          if (cmd.j == 4'd0) begin
            adth <= 16'(fill);
          end
        end
        OP_DATA: begin
          if (data_en) begin
            fill <= fill + OW'(1);
          end
          recv <= recv_new;
          if (last_r) begin
            in_packet <= 1'b0;
          end
        end
        OP_FIN: begin
          total_rd <= total;
          seq      <= seq + 16'd1;
          bank     <= ~bank;
          ready    <= 1'b1;
          fill     <= OW'(16);
          count    <= '0;
          cd       <= 16'd0;
          rp       <= '0;
          idx      <= '0;
        end
        OP_EMIT: begin
          out_status      <= res_status;
          out_byte        <= res_byte;
          out_frame_end   <= res_fend;
          out_frame_ready <= ready;
        end
        default: ;
      endcase
      if ((cmd.op == OP_TAB) && (cmd.j == 4'd7)) begin
        idx <= idx + IW'(1);
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/core/paf_ctrl.sv */
// ----------------------------------------------------------------------------
// Packet aggregation framer controller
// Sequences each accepted beat, packet openings and frame closing.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module paf_ctrl import paf_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire dp_stat_t stat,
  output dp_cmd_t       cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_DISP, S_READ, S_START, S_ZERO, S_DATA, S_TRY,
    S_PAD, S_ADTH, S_TAB, S_HDR, S_FIN, S_EMIT
  } state_t;

  state_t     state, state_next;
  logic [3:0] j, j_next;
  logic       ret, ret_next;

  always_comb begin
    state_next = state;
    j_next     = j + 4'd1;
    ret_next   = ret;
    cmd.op     = OP_NONE;
    cmd.j      = j;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op     = OP_LATCH;
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        state_next = S_TRY;
        case (stat.opcode)
          OPC_PKT: begin
            if (stat.dropping) begin
              cmd.op = OP_DROP;
            end else if (stat.in_packet) begin
              state_next = S_DATA;
            end else if (stat.too_large) begin
              cmd.op = OP_REJECT_BIG;
            end else if (stat.need_close) begin
              if (stat.frame_rdy) begin
                cmd.op = OP_REJECT_BUSY;
              end else begin
                state_next = S_PAD;
                ret_next   = 1'b1;
              end
            end else begin
              state_next = S_START;
            end
          end
          OPC_TICK: cmd.op = OP_TICK;
          OPC_READ: begin
            if (stat.frame_rdy) begin
              state_next = S_READ;
            end else begin
              cmd.op = OP_NOREAD;
            end
          end
          default: ;
        endcase
      end
      S_READ: begin
        cmd.op     = OP_READ;
        state_next = S_TRY;
      end
      S_START: begin
        cmd.op     = OP_PKT_START;
        state_next = S_ZERO;
      end
      S_ZERO: begin
        cmd.op = OP_ZERO;
        if (j == 4'd15) begin
          state_next = S_DATA;
        end
      end
      S_DATA: begin
        cmd.op     = OP_DATA;
        state_next = S_TRY;
      end
      S_TRY: begin
        if (stat.close_due) begin
          state_next = S_PAD;
          ret_next   = 1'b0;
        end else begin
          state_next = S_EMIT;
        end
      end
      S_PAD: begin
        if (stat.pad_done) begin
          state_next = S_ADTH;
        end else begin
          cmd.op = OP_PAD;
        end
      end
      S_ADTH: begin
        cmd.op = OP_ADTH;
        if (j == 4'd15) begin
          state_next = S_TAB;
        end
      end
      S_TAB: begin
        cmd.op = OP_TAB;
        if (j == 4'd7) begin
          j_next = 4'd0;
          if (stat.tab_last) begin
            state_next = S_HDR;
          end
        end
      end
      S_HDR: begin
        cmd.op = OP_HDR;
        if (j == 4'd15) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        cmd.op     = OP_FIN;
        state_next = ret ? S_START : S_EMIT;
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.op     = OP_EMIT;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
    if ((state_next != state) && !((state == S_TAB) && (state_next == S_TAB))) begin
      j_next = 4'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      j     <= 4'd0;
      ret   <= 1'b0;
    end else begin
      state <= state_next;
      j     <= j_next;
      ret   <= ret_next;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/packet_aggregation_framer.sv */
// Each accepted beat is latched, dispatched, then handled (a read, a packet byte, or a packet
// opening that first zeroes the packet header) before its result is emitted.
// Closing a frame pads to a 4-byte boundary, then writes the ADTH table and the frame header.
// A new beat is taken only after the previous result is placed in the output register,
// and a new beat is taken while the previous result waits in the output register.
// Reset is synchronous and active high; the frame store and bounds table are not cleared.
// ----------------------------------------------------------------------------
// Packet aggregation framer
// Packs packet bytes into aggregate frames in two ping-pong frame stores.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module packet_aggregation_framer import paf_pkg::*; #(
  parameter int FRAME_BYTES = 4096,
  parameter int MAX_PACKETS = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_wen,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_wdata,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [23:0] s_tdata,   // data_byte[7:0], packet_length[19:8], zero[23:20]
  input  wire logic [1:0]  s_tuser,   // opcode[1:0]
  input  wire logic        s_tlast,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata,   // out_byte[7:0], frame_ready[8], zero[15:9]
  output logic [1:0]       m_tuser,   // status[1:0]
  output logic             m_tlast
);

  dp_cmd_t    cmd;
  dp_stat_t   stat;
  logic [7:0] out_byte;
  logic       frame_ready;

  paf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  paf_datapath #(
    .FRAME_BYTES (FRAME_BYTES),
    .MAX_PACKETS (MAX_PACKETS)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .stat             (stat),
    .cfg_wen          (cfg_wen),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_opcode        (s_tuser),
    .in_data_byte     (s_tdata[7:0]),
    .in_packet_length (s_tdata[19:8]),
    .in_last_byte     (s_tlast),
    .out_valid        (m_tvalid),
    .out_taken        (m_tready),
    .out_status       (m_tuser),
    .out_byte         (out_byte),
    .out_frame_end    (m_tlast),
    .out_frame_ready  (frame_ready)
  );

  assign m_tdata = {7'd0, frame_ready, out_byte};

endmodule

`default_nettype wire

/* rtl/core/paf_checker.sv */
// ----------------------------------------------------------------------------
// Packet aggregation framer checker
// Port-level properties of the result stream, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "packet_aggregation_framer_defines.svh"

module paf_checker import paf_pkg::*; (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [15:0] m_tdata,
  input wire logic [1:0]  m_tuser,
  input wire logic        m_tlast
);

  `PAF_ASSERT(a_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result beat changed while stalled")
  `PAF_ASSERT(a_end_ok, m_tvalid && m_tlast |-> m_tuser == ST_OK, "frame end with error status")
  `PAF_ASSERT(a_noread_zero, m_tvalid && (m_tuser == ST_NOREAD) |-> m_tdata[7:0] == 8'd0, "empty read returned data")
  `PAF_ASSERT_ALWAYS(a_rst_idle, rst |=> !m_tvalid, "result valid after reset")

endmodule

bind packet_aggregation_framer paf_checker u_paf_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

`default_nettype wire

/* tb/framer_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Framer result checker
// Watches the input and output streams and the register port of the packet
// aggregation framer. It keeps its own copy of the frame banks and counters,
// works out the result of every accepted input beat and compares each output
// beat, field by field, with the oldest result still owed.
// ----------------------------------------------------------------------------

module framer_checker import paf_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_wen,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_wdata,
  input  wire logic        s_tvalid,
  input  wire logic        s_tready,
  input  wire logic [23:0] s_tdata,
  input  wire logic [1:0]  s_tuser,
  input  wire logic        s_tlast,
  input  wire logic        m_tvalid,
  input  wire logic        m_tready,
  input  wire logic [15:0] m_tdata,
  input  wire logic [1:0]  m_tuser,
  input  wire logic        m_tlast,
  output int               errors,
  output int               owed,
  output logic             frame_waiting
);

  localparam int BANK_BYTES = 4096;
  localparam int SLOTS = 64;

  typedef struct {
    logic [1:0]  status;
    logic [15:0] data;
    logic        fend;
  } result_t;

  result_t owed_results[$];

  logic [7:0]  banks [0:2*BANK_BYTES-1];
  logic [31:0] slot_bounds [0:SLOTS-1];
  logic [12:0] fill;
  logic [6:0]  pkt_count;
  logic [15:0] seq_no;
  logic [15:0] countdown;
  logic [12:0] rd_ptr;
  logic        fill_bank;
  logic        ready;
  logic [12:0] lim_frame;
  logic [6:0]  lim_pkts;
  logic [15:0] ticks;
  logic        in_pkt;
  logic        dropping;
  logic [1:0]  drop_status;
  logic [11:0] want_len;
  logic [11:0] got_len;
  logic [6:0]  slot;
  int          err_count;

  function automatic int unsigned align4(int unsigned x);
    return (x + 3) & ~32'd3;
  endfunction

  function automatic int unsigned frame_limit();
    if (lim_frame < 64) return 64;
    if (lim_frame > BANK_BYTES) return BANK_BYTES;
    return 32'(lim_frame);
  endfunction

  function automatic int unsigned packet_limit();
    if (lim_pkts < 1) return 1;
    if (lim_pkts > SLOTS) return SLOTS;
    return 32'(lim_pkts);
  endfunction

  function automatic bit room_for(int unsigned f, int unsigned n, int unsigned len);
    return align4(f + 16 + len) + 16 + 8 * (n + 1) <= frame_limit();
  endfunction

  task automatic put8(logic b, int unsigned off, logic [7:0] v);
    if (off < BANK_BYTES) banks[b * BANK_BYTES + off] = v;
  endtask

  task automatic put16(logic b, int unsigned off, logic [15:0] v);
    put8(b, off, v[7:0]);
    put8(b, off + 1, v[15:8]);
  endtask

  task automatic put32(logic b, int unsigned off, logic [31:0] v);
    put16(b, off, v[15:0]);
    put16(b, off + 2, v[31:16]);
  endtask

  function automatic logic [7:0] get8(logic b, int unsigned off);
    if (off < BANK_BYTES) return banks[b * BANK_BYTES + off];
    return 8'd0;
  endfunction

  task automatic seal_frame();
    int unsigned adth, total, n;
    logic b;
    b = fill_bank;
    n = 32'(pkt_count);
    adth = align4(32'(fill));
    for (int unsigned i = 32'(fill); i < adth; i++) put8(b, i, 8'h00);
    put8(b, adth, "A");
    put8(b, adth + 1, "D");
    put8(b, adth + 2, "T");
    put8(b, adth + 3, "H");
    put16(b, adth + 4, 16'(16 + 8 * n));
    put16(b, adth + 6, 16'd0);
    put32(b, adth + 8, 32'd0);
    put32(b, adth + 12, 32'd0);
    for (int unsigned i = 0; i < n && i < SLOTS; i++) begin
      put32(b, adth + 16 + 8 * i, {16'd0, slot_bounds[i][15:0]});
      put32(b, adth + 20 + 8 * i, {16'd0, slot_bounds[i][31:16]});
    end
    total = adth + 16 + 8 * n;
    put8(b, 0, "A");
    put8(b, 1, "D");
    put8(b, 2, "B");
    put8(b, 3, "H");
    put16(b, 4, 16'd0);
    put16(b, 6, seq_no);
    put16(b, 8, total[15:0]);
    put16(b, 10, 16'd0);
    put32(b, 12, adth);
    seq_no++;
    fill_bank = ~b;
    ready = 1'b1;
    fill = 13'd16;
    pkt_count = '0;
    countdown = '0;
    rd_ptr = '0;
  endtask

  task automatic frame_beat(logic [1:0] opc, logic [7:0] din, logic [11:0] plen,
                            logic lastb);
    result_t r;
    int unsigned len, total;
    logic rb;
    r.status = ST_OK;
    r.data = '0;
    r.fend = 1'b0;
    if (opc == OPC_PKT) begin
      if (dropping) begin
        r.status = drop_status;
        if (lastb) dropping = 1'b0;
      end else begin
        if (!in_pkt) begin
          len = (plen == 12'd0) ? 32'd1 : 32'(plen);
          if (!room_for(16, 0, len)) begin
            r.status = ST_BIG;
          end else if (pkt_count >= packet_limit() ||
                       !room_for(32'(fill), 32'(pkt_count), len)) begin
            if (ready) r.status = ST_BUSY;
            else seal_frame();
          end
          if (r.status != ST_OK) begin
            drop_status = r.status;
            dropping = !lastb;
          end else begin
            if (pkt_count == 0) countdown = (ticks == 0) ? 16'd1 : ticks;
            slot = pkt_count;
            if (slot < SLOTS) slot_bounds[slot] = {16'd0, 3'd0, fill};
            for (int unsigned i = 0; i < 16; i++) put8(fill_bank, 32'(fill) + i, 8'h00);
            fill += 13'd16;
            pkt_count++;
            want_len = 12'(len);
            got_len = '0;
            in_pkt = 1'b1;
          end
        end
        if (in_pkt) begin
          if (got_len < want_len) begin
            put8(fill_bank, 32'(fill), din);
            fill++;
            got_len++;
          end
          if (lastb) begin
            if (slot < SLOTS) slot_bounds[slot][31:16] = 16'(got_len) + 16'd16;
            in_pkt = 1'b0;
          end
        end
      end
    end else if (opc == OPC_TICK) begin
      if (pkt_count > 0 && countdown > 0) countdown--;
    end else if (opc == OPC_READ) begin
      if (ready) begin
        rb = ~fill_bank;
        total = {16'd0, get8(rb, 9), get8(rb, 8)};
        r.data[7:0] = get8(rb, 32'(rd_ptr));
        if (32'(rd_ptr) + 1 >= total) begin
          r.fend = 1'b1;
          rd_ptr = '0;
          ready = 1'b0;
        end else begin
          rd_ptr++;
        end
      end else begin
        r.status = ST_NOREAD;
      end
    end
    if (!in_pkt && !ready && pkt_count != 0 &&
        (pkt_count >= packet_limit() || countdown == 0)) seal_frame();
    r.data[8] = ready;
    owed_results.push_back(r);
  endtask

  initial begin
    for (int i = 0; i < 2 * BANK_BYTES; i++) banks[i] = 8'h00;
    for (int i = 0; i < SLOTS; i++) slot_bounds[i] = '0;
    err_count = 0;
    errors = 0;
    owed = 0;
    frame_waiting = 1'b0;
  end

  always @(posedge clk) begin
    result_t e;
    if (rst) begin
      fill = 13'd16;
      pkt_count = '0;
      seq_no = '0;
      countdown = '0;
      rd_ptr = '0;
      fill_bank = 1'b0;
      ready = 1'b0;
      lim_frame = 13'd4096;
      lim_pkts = 7'd4;
      ticks = 16'd100;
      in_pkt = 1'b0;
      dropping = 1'b0;
      drop_status = ST_OK;
      want_len = '0;
      got_len = '0;
      slot = '0;
      owed_results.delete();
    end else begin
      if (cfg_wen) begin
        case (cfg_index)
          REG_MAX_FRAME_BYTES: lim_frame = cfg_wdata[12:0];
          REG_MAX_PACKETS:     lim_pkts = cfg_wdata[6:0];
          REG_COALESCE_TICKS:  ticks = cfg_wdata;
          default: ;
        endcase
      end
      if (m_tvalid && m_tready) begin
        if (owed_results.size() == 0) begin
          $display("%0t: unexpected result beat, got status %0d data %h last %b",
                   $time, m_tuser, m_tdata, m_tlast);
          err_count++;
        end else begin
          e = owed_results.pop_front();
          if (m_tuser !== e.status) begin
            $display("%0t: status expected %0d got %0d", $time, e.status, m_tuser);
            err_count++;
          end
          if (m_tdata[7:0] !== e.data[7:0]) begin
            $display("%0t: out_byte expected %h got %h", $time, e.data[7:0], m_tdata[7:0]);
            err_count++;
          end
          if (m_tdata[8] !== e.data[8]) begin
            $display("%0t: frame_ready expected %b got %b", $time, e.data[8], m_tdata[8]);
            err_count++;
          end
          if (m_tdata[15:9] !== 7'd0) begin
            $display("%0t: tdata padding expected 0 got %h", $time, m_tdata[15:9]);
            err_count++;
          end
          if (m_tlast !== e.fend) begin
            $display("%0t: frame_end expected %b got %b", $time, e.fend, m_tlast);
            err_count++;
          end
        end
      end
      if (s_tvalid && s_tready) frame_beat(s_tuser, s_tdata[7:0], s_tdata[19:8], s_tlast);
    end
    errors <= err_count;
    owed <= owed_results.size();
    frame_waiting <= ready;
  end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Packet aggregation framer testbench
// Drives directed and random packet, tick, read and idle beats through several
// register settings, with random gaps and stalls on both streams and one long
// output stall. The checker instance predicts and compares every result.
// ----------------------------------------------------------------------------

module testbench;
  import paf_pkg::*;

  localparam logic [1:0] OPC_NOP = 2'd3;
  localparam int SETTLE = 700;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wen = 1'b0;
  logic [1:0]  cfg_index = REG_MAX_FRAME_BYTES;
  logic [15:0] cfg_wdata = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;
  logic [1:0]  s_tuser = OPC_NOP;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        m_tlast;
  int          errors;
  int          owed;
  logic        frame_waiting;
  bit          calm = 1'b0;
  bit          hold_req = 1'b0;
  int          hold_left = 0;
  int          beats_sent = 0;

  packet_aggregation_framer dut (.*);

  framer_checker chk (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #10000000;
    $display("testbench failed");
    $finish;
  end

  always @(posedge clk) begin
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left = 400;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      hold_left = $urandom_range(0, 3);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  task automatic send(logic [1:0] opc, logic [7:0] d, logic [11:0] len, logic lastb);
    if (!calm && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= opc;
    s_tdata <= {4'd0, len, d};
    s_tlast <= lastb;
    do @(posedge clk); while (!s_tready);
    beats_sent++;
  endtask

  task automatic send_rand(logic [1:0] opc);
    send(opc, 8'($urandom), 12'($urandom), 1'($urandom));
  endtask

  task automatic packet(int len, int nbytes, bit tick_inside);
    for (int i = 0; i < nbytes; i++) begin
      if (tick_inside && i == nbytes - 1) begin
        send_rand(OPC_TICK);
        send_rand(OPC_TICK);
      end
      send(OPC_PKT, 8'($urandom), (i == 0) ? len[11:0] : 12'($urandom), i == nbytes - 1);
    end
  endtask

  task automatic drain();
    while (frame_waiting) send_rand(OPC_READ);
    send_rand(OPC_READ);
  endtask

  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (owed != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic configure(logic [15:0] frame_bytes, logic [15:0] pkts, logic [15:0] tk);
    settle();
    cfg_wen <= 1'b1;
    cfg_index <= REG_MAX_FRAME_BYTES;
    cfg_wdata <= frame_bytes;
    @(posedge clk);
    cfg_index <= REG_MAX_PACKETS;
    cfg_wdata <= pkts;
    @(posedge clk);
    cfg_index <= REG_COALESCE_TICKS;
    cfg_wdata <= tk;
    @(posedge clk);
    cfg_wen <= 1'b0;
  endtask

  task automatic random_phase(int budget, int max_len);
    int stop_at, r, len, n;
    stop_at = beats_sent + budget;
    while (beats_sent < stop_at) begin
      r = $urandom_range(0, 99);
      if (r < 55) begin
        len = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 4095)
                                          : $urandom_range(1, max_len);
        n = (len == 0) ? 1 : len;
        if (n > 40) n = $urandom_range(1, 6);
        else if ($urandom_range(0, 9) == 0) n = n + $urandom_range(1, 3);
        else if ($urandom_range(0, 9) == 0) n = $urandom_range(1, n);
        packet(len, n, $urandom_range(0, 7) == 0);
      end else if (r < 70) begin
        repeat ($urandom_range(1, 8)) send_rand(OPC_TICK);
      end else if (r < 92) begin
        repeat ($urandom_range(1, 40)) send_rand(OPC_READ);
      end else begin
        send(($urandom_range(0, 1) == 0) ? OPC_NOP : OPC_PKT, 8'($urandom), 12'($urandom),
             1'b1);
      end
    end
    drain();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send(OPC_READ, 8'h00, 12'd0, 1'b0);
    send(OPC_NOP, 8'hFF, 12'hFFF, 1'b1);
    send(OPC_TICK, 8'h00, 12'd0, 1'b0);
    packet(0, 1, 1'b0);
    packet(4095, 2, 1'b0);
    packet(3, 5, 1'b0);
    packet(6, 2, 1'b0);
    send(OPC_TICK, 8'h00, 12'd0, 1'b0);
    packet(1, 1, 1'b0);
    drain();

    configure(16'd0, 16'd0, 16'd0);
    packet(8, 8, 1'b0);
    packet(2, 2, 1'b0);
    packet(2, 2, 1'b0);
    packet(9, 1, 1'b0);
    drain();
    drain();

    configure(16'd4096, 16'd64, 16'd2);
    packet(5, 5, 1'b1);
    send(OPC_TICK, 8'h00, 12'd0, 1'b0);
    drain();

    configure(16'd8191, 16'd127, 16'd65535);
    hold_req = 1'b1;
    random_phase(140, 60);
    configure(16'd64, 16'd1, 16'd1);
    random_phase(100, 8);
    configure(16'd200, 16'd3, 16'd5);
    random_phase(130, 30);
    configure(16'd1000, 16'd10, 16'd20);
    random_phase(130, 40);
    configure(16'($urandom_range(64, 4096)), 16'($urandom_range(1, 64)),
              16'($urandom_range(1, 30)));
    random_phase(120, 24);
    configure(16'd4096, 16'd4, 16'd100);
    calm = 1'b1;
    random_phase(80, 24);

    settle();
    if (errors == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl/core
rtl/core/paf_pkg.sv
rtl/core/paf_datapath.sv
rtl/core/paf_ctrl.sv
rtl/core/packet_aggregation_framer.sv
rtl/core/paf_checker.sv
tb/framer_checker.sv
tb/testbench.sv
